/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by level_set_face_density_interp
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a property holds on every rising clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that an antecedent in one cycle implies a consequent in the next
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lsfd_pkg.sv */
// ----------------------------------------------------------------------------
// lsfd_pkg
// shared types and constants for the face density interpolator
// ----------------------------------------------------------------------------
package lsfd_pkg;

   localparam int PHI_W = 32;
   localparam int RHO_W = 32;
   localparam int DIFF_W = PHI_W + 1;

   typedef enum logic [1:0] {
      WSEL_DIVIDE = 2'd0,
      WSEL_ZERO   = 2'd1,
      WSEL_ONE    = 2'd2
   } wsel_type;

endpackage

/* design/lsfd_pipe_ctl.sv */
// ----------------------------------------------------------------------------
// lsfd_pipe_ctl
// one pipeline stage valid bit with stall propagation
// ----------------------------------------------------------------------------
module lsfd_pipe_ctl import lsfd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   input  logic down_stall,
   output logic up_stall,
   output logic load,
   output logic valid_ff
);

   logic valid_in;

   // stage moves when empty or when downstream takes the word
   assign up_stall = valid_ff && down_stall;
   assign load     = !up_stall;
   assign valid_in = load ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

/* design/level_set_face_density_interp.sv */
// ----------------------------------------------------------------------------
// level_set_face_density_interp
// face density from two cells by level-set linear interpolation
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  req      | req_valid/req_stall  | phi_left, phi_right, rho_left, rho_right
//  rsp      | rsp_valid/rsp_stall  | rho_face
//
// one word per cycle while rsp is not stalled; WEIGHT_FRAC_BITS + 3 stages: a setup stage, a restoring
// divider with one quotient bit per stage, then a multiply stage and a sum stage.
// synchronous reset empties all stages; no payload reset.
// a stall on rsp holds the full stages from the output back to the first bubble; bubbles close up.
module level_set_face_density_interp import lsfd_pkg::*; #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_phi_left,
   input  logic signed [31:0]   req_phi_right,
   input  logic [31:0]          req_rho_left,
   input  logic [31:0]          req_rho_right,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_rho_face
);

   `include "assert_macros.svh"

   localparam int WF = WEIGHT_FRAC_BITS;
   localparam int NS = WF + 3;          // setup, WF divide steps, multiply, sum
   localparam int WW = WF + 1;
   localparam int PW = RHO_W + WW;
   localparam logic [WW-1:0] ONE_W = WW'(1) << WF;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] up_vld;
   logic [NS-1:0] ld;
   logic [NS:0]   stl;

   // per-stage payload
   logic [DIFF_W-1:0] rem_ff [0:WF-1];
   logic [DIFF_W-1:0] den_ff [0:WF-1];
   logic [WF-1:0]     quo_ff [0:WF];
   wsel_type          sel_ff [0:WF];
   logic [RHO_W-1:0]  rl_ff  [0:WF];
   logic [RHO_W-1:0]  rr_ff  [0:WF];
   logic [PW-1:0]     pl_ff, pr_ff;
   logic [RHO_W-1:0]  out_ff;

   assign stl[NS] = rsp_stall;
   assign up_vld  = {vld_ff[NS-2:0], req_valid};

   genvar g;
   generate
      for (g = 0; g < NS; g++) begin : g_ctl
         lsfd_pipe_ctl u_ctl (
            .clock(clock), .reset(reset),
            .up_valid(up_vld[g]),
            .down_stall(stl[g+1]), .up_stall(stl[g]),
            .load(ld[g]), .valid_ff(vld_ff[g])
         );
      end
   endgenerate

   assign req_stall = stl[0];
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_rho_face = out_ff;

   // setup stage: difference, magnitudes, special cases
   logic signed [DIFF_W-1:0] diff_s, num_s;
   logic [DIFF_W-1:0] an, ad;
   wsel_type sel_in;
   always_comb begin
      diff_s = DIFF_W'(req_phi_right) - DIFF_W'(req_phi_left);
      num_s  = -DIFF_W'(req_phi_left);
      an = num_s[DIFF_W-1] ? DIFF_W'(-num_s) : num_s;
      ad = diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : diff_s;
      if (diff_s == '0) begin
         sel_in = WSEL_ONE;
      end else if (num_s == '0 || (num_s[DIFF_W-1] != diff_s[DIFF_W-1])) begin
         sel_in = WSEL_ZERO;
      end else if (an >= ad) begin
         sel_in = WSEL_ONE;
      end else begin
         sel_in = WSEL_DIVIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         rem_ff[0] <= an;
         den_ff[0] <= ad;
         quo_ff[0] <= '0;
         sel_ff[0] <= sel_in;
         rl_ff[0]  <= req_rho_left;
         rr_ff[0]  <= req_rho_right;
      end
   end

   // restoring divide, one quotient bit per stage; remainder stays below den for WSEL_DIVIDE words
   generate
      for (g = 1; g <= WF; g++) begin : g_div
         logic [DIFF_W:0] trial;
         logic            take;
         assign trial = {rem_ff[g-1], 1'b0};
         assign take  = trial >= {1'b0, den_ff[g-1]};
         always_ff @(posedge clock) begin
            if (ld[g]) begin
               quo_ff[g] <= {quo_ff[g-1][WF-2:0], take};
               sel_ff[g] <= sel_ff[g-1];
               rl_ff[g]  <= rl_ff[g-1];
               rr_ff[g]  <= rr_ff[g-1];
            end
         end
         // last step needs only the quotient
         if (g < WF) begin : g_rem
            always_ff @(posedge clock) begin
               if (ld[g]) begin
                  rem_ff[g] <= take ? DIFF_W'(trial - {1'b0, den_ff[g-1]})
                                    : DIFF_W'(trial);
                  den_ff[g] <= den_ff[g-1];
               end
            end
         end
      end
   endgenerate

   // weights and products
   logic [WW-1:0] wl, wr;
   always_comb begin
      unique case (sel_ff[WF])
         WSEL_ONE:  wl = ONE_W;
         WSEL_ZERO: wl = '0;
         default:   wl = {1'b0, quo_ff[WF]};
      endcase
      wr = ONE_W - wl;
   end

   always_ff @(posedge clock) begin
      if (ld[WF+1]) begin
         pl_ff <= PW'(wl) * PW'(rl_ff[WF]);
         pr_ff <= PW'(wr) * PW'(rr_ff[WF]);
      end
   end

   // sum and scale; weights sum to one so the result fits
   logic [PW:0] acc;
   logic [PW:0] res;
   assign acc = {1'b0, pl_ff} + {1'b0, pr_ff};
   assign res = acc >> WF;

   always_ff @(posedge clock) begin
      if (ld[WF+2]) begin
         out_ff <= (res > (PW+1)'({RHO_W{1'b1}})) ? {RHO_W{1'b1}} : res[RHO_W-1:0];
      end
   end

   `CHECK_NEXT(a_hold_out, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_rho_face), "result changed under stall")
   `CHECK_ALWAYS(a_stall_full, clock, reset, !req_stall || (&vld_ff),
      "input stalled with a bubble in the pipe")
   `CHECK_NEXT(a_move, clock, reset, rsp_valid && !rsp_stall && vld_ff[NS-2],
      rsp_valid, "word lost at the output stage")

endmodule
